FILE: rtl/swrm_pkg.sv
// Shared types and constants of the sliding-window rate meter.
package swrm_pkg;

    // Field widths.
    localparam int DATA_W  = 64;
    localparam int SCALE_W = 13;
    localparam int PROD_W  = DATA_W + SCALE_W;

    // Bits per byte times milliseconds per second.
    localparam logic [SCALE_W-1:0] SPEED_SCALE = 13'd8000;

    // Serial multiplier carry and column sum widths.
    localparam int CARRY_W = 3;
    localparam int SUM_W   = 4;

    // Lanes of the serial subtractors and of the rate datapath.
    localparam int SUB_LANES  = 3;
    localparam int RATE_LANES = 2;
    localparam int LANE_RX    = 0;
    localparam int LANE_TX    = 1;
    localparam int LANE_TIME  = 2;

    // Step counter and the last step of each phase.
    localparam int STEP_W = 7;
    localparam logic [STEP_W-1:0] SERIAL_LAST = 7'(PROD_W - 1);
    localparam logic [STEP_W-1:0] DIV_LAST    = 7'(DATA_W - 1);
    localparam logic [STEP_W-1:0] SUB_STEPS   = 7'(DATA_W);

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SERIAL,
        ST_SETUP,
        ST_DIV,
        ST_DONE
    } state_t;

    // One sample of the window.
    typedef struct packed {
        logic [DATA_W-1:0] time_ms;
        logic [DATA_W-1:0] tx;
        logic [DATA_W-1:0] rx;
    } sample_t;

    // Decoded controls of the sequencer.
    typedef struct packed {
        logic take_in;
        logic load_old;
        logic serial;
        logic setup;
        logic divide;
        logic load_out;
    } ctrl_t;

endpackage

FILE: rtl/sliding_window_rate_meter_top.sv
// Sliding-window rate meter: sample window, bit-serial differences and scaling, dividers.
//
//  Channel   Direction  Handshake                Contents (lowest bits first)
//  s_*       in         s_tvalid / s_tready      rx_bytes, tx_bytes, timestamp_ms
//  m_*       out        m_tvalid / m_tready      rx_bits_per_sec, tx_bits_per_sec, window_fill
//  cfg_*     in         cfg_valid / cfg_ready    start_time_ms
//
// An item passes through these steps from acceptance to the next acceptance: one memory read, 77 bit-serial
// steps of subtraction and scaling by 8000, a setup state, 64 steps of the two radix-2 dividers
// (rx and tx side by side) and the loading of the output register.
// Reset leaves the window holding the single zero sample at start time 0; a configuration write,
// taken only between items and ahead of a waiting input word, restarts the window the same way.
// A stalled output word holds in its register; the next item is accepted meanwhile and waits in
// its last state only if the previous word has still not been taken.
module sliding_window_rate_meter_top #(
    parameter int WINDOW_DEPTH = 4,
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1),
    localparam int OUT_W  = ((2 * swrm_pkg::DATA_W + FILL_W + 7) / 8) * 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // rx_bytes, tx_bytes, timestamp_ms
    input  logic [3*swrm_pkg::DATA_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // rx_bits_per_sec, tx_bits_per_sec, window_fill, zero fill
    output logic [OUT_W-1:0]                 m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    // start_time_ms
    input  logic [swrm_pkg::DATA_W-1:0]      cfg_data
);

    localparam int PTR_W = $clog2(WINDOW_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
    localparam logic [FILL_W-1:0] FILL_ONE  = FILL_W'(1);
    localparam int DW = swrm_pkg::DATA_W;
    localparam int PW = swrm_pkg::PROD_W;
    localparam int KW = swrm_pkg::SCALE_W;

    swrm_pkg::state_t state_reg;
    swrm_pkg::state_t state_next;
    swrm_pkg::ctrl_t  ctrl;

    logic [swrm_pkg::STEP_W-1:0] step_reg;
    logic [DW-1:0]               start_time_reg;
    logic [PTR_W-1:0]            newest_reg;
    logic [PTR_W-1:0]            newest_next;
    logic [PTR_W-1:0]            oldest_slot;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;
    logic                        init_live_reg;
    logic                        use_init_reg;
    logic                        m_tvalid_reg;
    logic                        s_accept;

    swrm_pkg::sample_t mem [WINDOW_DEPTH];
    swrm_pkg::sample_t rd_reg;
    swrm_pkg::sample_t in_sample;
    swrm_pkg::sample_t old_sample;

    // Serial subtractor lanes: rx, tx, time.
    logic [DW-1:0] a_reg      [swrm_pkg::SUB_LANES];
    logic [DW-1:0] b_reg      [swrm_pkg::SUB_LANES];
    logic          borrow_reg [swrm_pkg::SUB_LANES];
    logic          borrow_next[swrm_pkg::SUB_LANES];
    logic          dbit       [swrm_pkg::SUB_LANES];
    logic          sub_active;
    logic [DW-1:0] span_reg;

    // Rate lanes: rx, tx.
    logic [KW-1:0]                 win_reg   [swrm_pkg::RATE_LANES];
    logic [KW-1:0]                 win_new   [swrm_pkg::RATE_LANES];
    logic [swrm_pkg::CARRY_W-1:0]  carry_reg [swrm_pkg::RATE_LANES];
    logic [swrm_pkg::SUM_W-1:0]    col_sum   [swrm_pkg::RATE_LANES];
    logic [PW-1:0]                 prod_reg  [swrm_pkg::RATE_LANES];
    logic [DW-1:0]                 rem_reg   [swrm_pkg::RATE_LANES];
    logic [DW-1:0]                 quo_reg   [swrm_pkg::RATE_LANES];
    logic [DW:0]                   rem_ext   [swrm_pkg::RATE_LANES];
    logic [DW:0]                   rem_sub   [swrm_pkg::RATE_LANES];
    logic                          rem_ge    [swrm_pkg::RATE_LANES];
    logic                          sat_reg   [swrm_pkg::RATE_LANES];
    logic                          zero_span_reg;
    logic [DW-1:0]                 out_rate_reg [swrm_pkg::RATE_LANES];
    logic [FILL_W-1:0]             out_fill_reg;

    assign in_sample = swrm_pkg::sample_t'(s_tdata);

    // Window pointers for the item being accepted.
    always_comb
    begin
        newest_next = (newest_reg == PTR_LAST) ? '0 : newest_reg + 1'b1;
        fill_next   = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
        if (fill_next == FILL_FULL)
        begin
            oldest_slot = (newest_next == PTR_LAST) ? '0 : newest_next + 1'b1;
        end
        else
        begin
            oldest_slot = '0;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swrm_pkg::ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = swrm_pkg::ST_LOAD;
                end
            end
            swrm_pkg::ST_LOAD:
            begin
                state_next = swrm_pkg::ST_SERIAL;
            end
            swrm_pkg::ST_SERIAL:
            begin
                if (step_reg == swrm_pkg::SERIAL_LAST)
                begin
                    state_next = swrm_pkg::ST_SETUP;
                end
            end
            swrm_pkg::ST_SETUP:
            begin
                state_next = swrm_pkg::ST_DIV;
            end
            swrm_pkg::ST_DIV:
            begin
                if (step_reg == swrm_pkg::DIV_LAST)
                begin
                    state_next = swrm_pkg::ST_DONE;
                end
            end
            swrm_pkg::ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = swrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Decoded controls.
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            swrm_pkg::ST_IDLE:   ctrl.take_in  = 1'b1;
            swrm_pkg::ST_LOAD:   ctrl.load_old = 1'b1;
            swrm_pkg::ST_SERIAL: ctrl.serial   = 1'b1;
            swrm_pkg::ST_SETUP:  ctrl.setup    = 1'b1;
            swrm_pkg::ST_DIV:    ctrl.divide   = 1'b1;
            swrm_pkg::ST_DONE:   ctrl.load_out = !m_tvalid_reg || m_tready;
            default:             ctrl = '0;
        endcase
    end

    // A configuration write is taken only between items and goes ahead of a waiting input word.
    assign s_tready  = ctrl.take_in && !cfg_valid;
    assign cfg_ready = ctrl.take_in;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;

    // Sequencer, window bookkeeping and configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= swrm_pkg::ST_IDLE;
            step_reg       <= '0;
            start_time_reg <= '0;
            newest_reg     <= '0;
            fill_reg       <= FILL_ONE;
            init_live_reg  <= 1'b1;
            use_init_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_next != state_reg) ? '0 : step_reg + 1'b1;
            if (cfg_valid && cfg_ready)
            begin
                start_time_reg <= cfg_data;
                newest_reg     <= '0;
                fill_reg       <= FILL_ONE;
                init_live_reg  <= 1'b1;
            end
            else if (s_accept)
            begin
                newest_reg   <= newest_next;
                fill_reg     <= fill_next;
                use_init_reg <= (oldest_slot == '0) && init_live_reg;
                if (newest_next == '0)
                begin
                    init_live_reg <= 1'b0;
                end
            end
            if (ctrl.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Sample memory: the new sample is written while the oldest one is read.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            mem[newest_next] <= in_sample;
            rd_reg           <= mem[oldest_slot];
        end
    end

    // The initial zero sample lives outside the memory.
    always_comb
    begin
        if (use_init_reg)
        begin
            old_sample         = '0;
            old_sample.time_ms = start_time_reg;
        end
        else
        begin
            old_sample = rd_reg;
        end
    end

    // Bit-serial subtraction, least significant bit first.
    assign sub_active = step_reg < swrm_pkg::SUB_STEPS;

    always_comb
    begin
        for (int l = 0; l < swrm_pkg::SUB_LANES; l++)
        begin
            dbit[l]        = sub_active & (a_reg[l][0] ^ b_reg[l][0] ^ borrow_reg[l]);
            borrow_next[l] = (~a_reg[l][0] & b_reg[l][0])
                           | (~(a_reg[l][0] ^ b_reg[l][0]) & borrow_reg[l]);
        end
    end

    // Serial multiply by the speed scale: column sum of the recent difference bits.
    always_comb
    begin
        for (int l = 0; l < swrm_pkg::RATE_LANES; l++)
        begin
            win_new[l] = {win_reg[l][KW-2:0], dbit[l]};
            col_sum[l] = swrm_pkg::SUM_W'(carry_reg[l]);
            for (int j = 0; j < KW; j++)
            begin
                if (swrm_pkg::SPEED_SCALE[j])
                begin
                    col_sum[l] = col_sum[l] + swrm_pkg::SUM_W'(win_new[l][j]);
                end
            end
        end
    end

    // Restoring divider step: shift in the next dividend bit, subtract the span if it fits.
    always_comb
    begin
        for (int l = 0; l < swrm_pkg::RATE_LANES; l++)
        begin
            rem_ext[l] = {rem_reg[l], quo_reg[l][DW-1]};
            rem_sub[l] = rem_ext[l] - {1'b0, span_reg};
            rem_ge[l]  = rem_ext[l] >= {1'b0, span_reg};
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            a_reg[swrm_pkg::LANE_RX]   <= in_sample.rx;
            a_reg[swrm_pkg::LANE_TX]   <= in_sample.tx;
            a_reg[swrm_pkg::LANE_TIME] <= in_sample.time_ms;
        end
        if (ctrl.load_old)
        begin
            b_reg[swrm_pkg::LANE_RX]   <= old_sample.rx;
            b_reg[swrm_pkg::LANE_TX]   <= old_sample.tx;
            b_reg[swrm_pkg::LANE_TIME] <= old_sample.time_ms;
            for (int l = 0; l < swrm_pkg::SUB_LANES; l++)
            begin
                borrow_reg[l] <= 1'b0;
            end
            for (int l = 0; l < swrm_pkg::RATE_LANES; l++)
            begin
                win_reg[l]   <= '0;
                carry_reg[l] <= '0;
            end
        end
        if (ctrl.serial)
        begin
            if (sub_active)
            begin
                for (int l = 0; l < swrm_pkg::SUB_LANES; l++)
                begin
                    a_reg[l]      <= {1'b0, a_reg[l][DW-1:1]};
                    b_reg[l]      <= {1'b0, b_reg[l][DW-1:1]};
                    borrow_reg[l] <= borrow_next[l];
                end
                span_reg <= {dbit[swrm_pkg::LANE_TIME], span_reg[DW-1:1]};
            end
            for (int l = 0; l < swrm_pkg::RATE_LANES; l++)
            begin
                win_reg[l]   <= win_new[l];
                carry_reg[l] <= col_sum[l][swrm_pkg::SUM_W-1:1];
                prod_reg[l]  <= {col_sum[l][0], prod_reg[l][PW-1:1]};
            end
        end
        if (ctrl.setup)
        begin
            zero_span_reg <= span_reg == '0;
            for (int l = 0; l < swrm_pkg::RATE_LANES; l++)
            begin
                rem_reg[l] <= DW'(prod_reg[l][PW-1:DW]);
                quo_reg[l] <= prod_reg[l][DW-1:0];
                sat_reg[l] <= (span_reg[DW-1:KW] == '0)
                           && (prod_reg[l][PW-1:DW] >= span_reg[KW-1:0]);
            end
        end
        if (ctrl.divide)
        begin
            for (int l = 0; l < swrm_pkg::RATE_LANES; l++)
            begin
                rem_reg[l] <= rem_ge[l] ? rem_sub[l][DW-1:0] : rem_ext[l][DW-1:0];
                quo_reg[l] <= {quo_reg[l][DW-2:0], rem_ge[l]};
            end
        end
        if (ctrl.load_out)
        begin
            for (int l = 0; l < swrm_pkg::RATE_LANES; l++)
            begin
                if (zero_span_reg)
                begin
                    out_rate_reg[l] <= '0;
                end
                else if (sat_reg[l])
                begin
                    out_rate_reg[l] <= '1;
                end
                else
                begin
                    out_rate_reg[l] <= quo_reg[l];
                end
            end
            out_fill_reg <= fill_reg;
        end
    end

    // Output word packing.
    always_comb
    begin
        m_tdata                        = '0;
        m_tdata[DW-1:0]                = out_rate_reg[swrm_pkg::LANE_RX];
        m_tdata[2*DW-1:DW]             = out_rate_reg[swrm_pkg::LANE_TX];
        m_tdata[2*DW +: FILL_W]        = out_fill_reg;
    end

endmodule

FILE: rtl/swrm_checker.sv
// Port-level checks of the sliding-window rate meter and their binding.
module swrm_checker #(
    parameter int WINDOW_DEPTH = 4,
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1),
    localparam int OUT_W  = ((2 * swrm_pkg::DATA_W + FILL_W + 7) / 8) * 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [OUT_W-1:0]              m_tdata,
    input logic                          cfg_valid,
    input logic                          cfg_ready
);

    logic [FILL_W-1:0] fill;

    assign fill = m_tdata[2*swrm_pkg::DATA_W +: FILL_W];

    // An accepted word keeps the block busy for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on two consecutive cycles");

    // A result cannot appear in the cycle after its word is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // The window always holds between one and the full depth of samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (fill != '0) && (fill <= FILL_W'(WINDOW_DEPTH)))
        else $error("window fill out of range");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled output word changed");

    // A configuration write never shares its cycle with an input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(s_tvalid && s_tready))
        else $error("configuration write taken together with an input word");

endmodule

bind sliding_window_rate_meter_top swrm_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_swrm_checker (.*);

FILE: tb/rate_meter_checker.sv
// Checker for the rate meter: tracks the sample window, predicts each speed word and compares it.
module rate_meter_checker #(
    parameter int WINDOW_DEPTH = 4,
    parameter int FILL_W = 3,
    parameter int OUT_W = 136
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // rx_bytes, tx_bytes, timestamp_ms
    input  logic [3*swrm_pkg::DATA_W-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // rx_bits_per_sec, tx_bits_per_sec, window_fill, zero fill
    input  logic [OUT_W-1:0]                 m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    // start_time_ms
    input  logic [swrm_pkg::DATA_W-1:0]      cfg_data,
    output int                               mismatch_count,
    output int                               reports_due
);

    localparam int DW = swrm_pkg::DATA_W;

    typedef logic [DW-1:0] word_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        word_t             tx_bps;
        word_t             rx_bps;
    } speed_report_t;

    // Private copy of the sample window.
    word_t rx_window [WINDOW_DEPTH];
    word_t tx_window [WINDOW_DEPTH];
    word_t ms_window [WINDOW_DEPTH];
    int    head_slot;
    int    samples_held;
    int    oldest_slot;
    word_t span_ms;

    speed_report_t speed_reports [$];
    speed_report_t predicted;
    speed_report_t oldest_report;

    // Bits per second over a span: exact wide product, saturating quotient, zero for no span.
    function automatic word_t scaled_speed(input word_t byte_delta, input word_t span);
        logic [2*DW-1:0] product;
        logic [2*DW-1:0] quotient;
        if (span == '0)
            return '0;
        product = {{DW{1'b0}}, byte_delta} * (2*DW)'(swrm_pkg::SPEED_SCALE);
        quotient = product / {{DW{1'b0}}, span};
        if (quotient[2*DW-1:DW] != '0)
            return '1;
        return quotient[DW-1:0];
    endfunction

    // The window restarts with one zero sample at the given start time.
    function automatic void restart_window(input word_t start_ms);
        rx_window[0] = '0;
        tx_window[0] = '0;
        ms_window[0] = start_ms;
        head_slot = 0;
        samples_held = 1;
    endfunction

    task automatic check_field(input string field, input word_t want, input word_t got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Follow the three channels, one word per handshake.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_window('0);
            speed_reports.delete();
            mismatch_count = 0;
            reports_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                restart_window(cfg_data);

            // A new sample enters the window and yields one speed word.
            if (s_tvalid && s_tready)
            begin
                head_slot = (head_slot + 1) % WINDOW_DEPTH;
                rx_window[head_slot] = s_tdata[DW-1:0];
                tx_window[head_slot] = s_tdata[2*DW-1:DW];
                ms_window[head_slot] = s_tdata[3*DW-1:2*DW];
                if (samples_held < WINDOW_DEPTH)
                    samples_held++;
                oldest_slot = (head_slot + WINDOW_DEPTH - (samples_held - 1)) % WINDOW_DEPTH;
                span_ms = ms_window[head_slot] - ms_window[oldest_slot];
                predicted.rx_bps = scaled_speed(rx_window[head_slot] - rx_window[oldest_slot],
                                                span_ms);
                predicted.tx_bps = scaled_speed(tx_window[head_slot] - tx_window[oldest_slot],
                                                span_ms);
                predicted.fill = samples_held[FILL_W-1:0];
                speed_reports.push_back(predicted);
            end

            // Each speed word taken is held against the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                if (speed_reports.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: speed word expected none, got rx %0d tx %0d fill %0d",
                             $time, m_tdata[DW-1:0], m_tdata[2*DW-1:DW],
                             m_tdata[2*DW +: FILL_W]);
                end
                else
                begin
                    oldest_report = speed_reports.pop_front();
                    check_field("rx_bits_per_sec", oldest_report.rx_bps, m_tdata[DW-1:0]);
                    check_field("tx_bits_per_sec", oldest_report.tx_bps,
                                m_tdata[2*DW-1:DW]);
                    check_field("window_fill", word_t'(oldest_report.fill),
                                word_t'(m_tdata[2*DW +: FILL_W]));
                end
            end

            reports_due = speed_reports.size();
        end
    end

endmodule

FILE: tb/tb_sliding_window_rate_meter_top.sv
// Testbench top of the sliding-window rate meter: clock, reset, stimulus, idling and verdict.
module tb_sliding_window_rate_meter_top;

    localparam int DW = swrm_pkg::DATA_W;
    localparam int WINDOW_DEPTH = 4;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int OUT_W = ((2 * DW + FILL_W + 7) / 8) * 8;
    localparam int POLLS_PER_PHASE = 180;
    localparam int POLLS_PER_SETTING = 60;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT = 1000000;

    typedef logic [DW-1:0] word_t;

    localparam word_t ALL_ONES = '1;
    localparam word_t TOP_BIT = word_t'(1) << (DW - 1);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [3*DW-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [DW-1:0]         cfg_data;

    int    send_idle_pct;
    int    recv_idle_pct;
    int    mismatch_count;
    int    reports_due;
    int    cycle_count = 0;

    // Running counters of the polled interface.
    word_t rx_count;
    word_t tx_count;
    word_t now_ms;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sliding_window_rate_meter_top #(
        .WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    rate_meter_checker #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .FILL_W(FILL_W),
        .OUT_W(OUT_W)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .mismatch_count(mismatch_count),
        .reports_due(reports_due)
    );

    // The receiver stalls at random on every falling edge.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Hard stop if the run hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_sliding_window_rate_meter_top NOT OK");
            $finish;
        end
    end

    function automatic word_t random_word();
        return {$urandom, $urandom};
    endfunction

    // Byte increment between polls, mostly modest, sometimes large enough to saturate.
    function automatic word_t byte_increment();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            return word_t'($urandom_range(0, 100000));
        else if (pick < 80)
            return word_t'($urandom);
        else if (pick < 95)
            return {16'd0, 16'($urandom_range(0, 65535)), $urandom};
        return random_word();
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_poll(input word_t rx, input word_t tx, input word_t ts);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ts, tx, rx};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Hold off the sender until every speed word has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (reports_due != 0)
            @(negedge clk);
    endtask

    // Restart the window at a new start time while the block is idle.
    task automatic write_start_time(input word_t start_ms);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= start_ms;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One random poll: mostly a forward-moving sequence, some broken ones and pure noise.
    task automatic send_random_poll();
        int pick;
        int gap_pick;
        pick = $urandom_range(0, 99);
        if (pick < 78)
        begin
            gap_pick = $urandom_range(0, 99);
            if (gap_pick < 15)
                now_ms = now_ms;
            else if (gap_pick < 85)
                now_ms += word_t'($urandom_range(1, 2000));
            else if (gap_pick < 95)
                now_ms += word_t'($urandom_range(1, 1 << 24));
            else
                now_ms += {24'd0, 8'($urandom_range(0, 255)), $urandom};
            rx_count += byte_increment();
            tx_count += byte_increment();
        end
        else if (pick < 90)
        begin
            // Counters wrap back and the clock steps backwards.
            rx_count -= word_t'($urandom_range(0, 1 << 20));
            tx_count -= word_t'($urandom_range(0, 1 << 20));
            now_ms -= word_t'($urandom_range(1, 5000));
        end
        else
        begin
            rx_count = random_word();
            tx_count = random_word();
            now_ms = random_word();
        end
        send_poll(rx_count, tx_count, now_ms);
    endtask

    initial
    begin
        int idle_phase;
        int poll;
        word_t start_ms;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 17;
        recv_idle_pct = 49;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset start time: zero elapsed, filling, dropping the oldest, clock going back.
        send_poll(word_t'(0), word_t'(0), word_t'(0));
        send_poll(word_t'(1000), word_t'(500), word_t'(1000));
        send_poll(word_t'(3000), word_t'(1000), word_t'(2000));
        send_poll(word_t'(4000), word_t'(2000), word_t'(3000));
        send_poll(word_t'(4500), word_t'(2500), word_t'(1000));
        send_poll(ALL_ONES, word_t'(1), word_t'(1001));
        send_poll(word_t'(0), ALL_ONES, ALL_ONES);
        send_poll(ALL_ONES, word_t'(0), word_t'(0));
        send_poll(word_t'(5), word_t'(5), word_t'(0));

        // Start time at its top: spans wrap through zero, wide products, equal stamps.
        write_start_time(ALL_ONES);
        send_poll(word_t'(0), word_t'(0), ALL_ONES);
        send_poll(word_t'(125), word_t'(250), word_t'(0));
        send_poll(word_t'(125), word_t'(250), word_t'(0));
        send_poll(word_t'(1) << 60, word_t'(1) << 59, word_t'(1048575));
        send_poll(ALL_ONES, ALL_ONES, word_t'(1048575));

        // Start time at zero: largest counters over the shortest span.
        write_start_time('0);
        send_poll(ALL_ONES, ALL_ONES, word_t'(1));
        send_poll(word_t'(1), word_t'(0), word_t'(2));
        send_poll(TOP_BIT, TOP_BIT - 1, TOP_BIT);
        wait_drained();

        // Random part in three idling phases, with a fresh start time every few dozen polls.
        for (idle_phase = 0; idle_phase < 3; idle_phase++)
        begin
            send_idle_pct = (idle_phase == 0) ? 17 : (idle_phase == 1) ? 49 : 0;
            recv_idle_pct = (idle_phase == 0) ? 49 : (idle_phase == 1) ? 17 : 0;
            for (poll = 0; poll < POLLS_PER_PHASE; poll++)
            begin
                if (poll % POLLS_PER_SETTING == 0)
                begin
                    start_ms = ($urandom_range(0, 1) == 1) ? random_word()
                                                          : word_t'($urandom);
                    write_start_time(start_ms);
                    now_ms = start_ms + word_t'($urandom_range(0, 3000));
                    rx_count = ($urandom_range(0, 1) == 1) ? random_word()
                                                          : word_t'($urandom_range(0, 1000));
                    tx_count = ($urandom_range(0, 1) == 1) ? random_word()
                                                          : word_t'($urandom_range(0, 1000));
                end
                else if ($urandom_range(0, 49) == 0)
                    wait_drained();
                send_random_poll();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("tb_sliding_window_rate_meter_top OK");
        else
            $display("tb_sliding_window_rate_meter_top NOT OK");
        $finish;
    end

endmodule
